// ===== hw/rtl/fac_pkg.sv =====
// shared types, codes and sizes for the frustum box culling block
// no dependencies; imported by every module of the block

package fac_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PLANE_W    = 3;
    localparam int COEF_W     = 2;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int D_SHIFT    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [COEF_W-1:0] COEF_NX = 2'd0;
    localparam logic [COEF_W-1:0] COEF_NY = 2'd1;
    localparam logic [COEF_W-1:0] COEF_NZ = 2'd2;
    localparam logic [COEF_W-1:0] COEF_D  = 2'd3;

    localparam logic [1:0] VERDICT_OUT_BOX   = 2'd0;
    localparam logic [1:0] VERDICT_OUT_PLANE = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd2;
    localparam logic [1:0] VERDICT_CROSS     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    typedef logic [2:0][VAL_W-1:0] t_vec3;

    typedef struct packed {
        logic out_box;
        logic out_plane;
        logic crossing;
    } t_flags;

    typedef struct packed {
        logic               opcode;
        logic [PLANE_W-1:0] plane_slot;
        logic [COEF_W-1:0]  coef_slot;
        logic [VAL_W-1:0]   coef_value;
        t_vec3              lo;
        t_vec3              hi;
        t_flags             flags;
    } t_item;

endpackage

// ===== hw/rtl/fac_box_cell.sv =====
// head cell of the chain: overlap test of the box against the frustum bounding box
// depends on fac_pkg

module fac_box_cell
    import fac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_vec3 i_fmin,
    input  t_vec3 i_fmax,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_out;

    always_comb begin
        w_out = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if ($signed(i_item.lo[a]) > $signed(i_fmax[a]) ||
                $signed(i_fmin[a]) > $signed(i_item.hi[a])) begin
                w_out = 1'b1;
            end
        end
        n_item                 = i_item;
        n_item.flags.out_box   = w_out;
        n_item.flags.out_plane = 1'b0;
        n_item.flags.crossing  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/fac_plane_cell.sv =====
// one plane of the chain: holds its plane words, forms near/far products, then signs
// depends on fac_pkg

module fac_plane_cell
    import fac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [PLANE_W-1:0] i_idx,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_valid,
    output t_item              o_item
);

    logic [VAL_W-1:0]         r_coef [4];
    logic                     r_s1_valid;
    t_item                    r_s1_item;
    logic signed [PROD_W-1:0] r_pn [3];
    logic signed [PROD_W-1:0] r_pf [3];
    logic                     r_s2_valid;
    t_item                    r_s2_item;

    logic signed [PROD_W-1:0] n_pn [3];
    logic signed [PROD_W-1:0] n_pf [3];
    logic signed [SUM_W-1:0]  w_d;
    logic signed [SUM_W-1:0]  w_sum_n;
    logic signed [SUM_W-1:0]  w_sum_f;
    logic                     w_pos_n;
    logic                     w_pos_f;
    t_item                    n_s2_item;

    // near corner takes the minimum where the normal is non-negative
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_coef[a][VAL_W-1]) begin
                n_pn[a] = $signed(r_coef[a]) * $signed(i_item.hi[a]);
                n_pf[a] = $signed(r_coef[a]) * $signed(i_item.lo[a]);
            end else begin
                n_pn[a] = $signed(r_coef[a]) * $signed(i_item.lo[a]);
                n_pf[a] = $signed(r_coef[a]) * $signed(i_item.hi[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_item.opcode == OP_LOAD && i_item.plane_slot == i_idx) begin
            r_coef[i_item.coef_slot] <= i_item.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item <= i_item;
            for (int a = 0; a < 3; a++) begin
                r_pn[a] <= n_pn[a];
                r_pf[a] <= n_pf[a];
            end
            r_s2_item <= n_s2_item;
        end
    end

    always_comb begin
        w_d = {{(SUM_W-VAL_W-D_SHIFT){r_coef[COEF_D][VAL_W-1]}}, r_coef[COEF_D],
               {D_SHIFT{1'b0}}};
        w_sum_n = SUM_W'(r_pn[0]) + SUM_W'(r_pn[1]) + SUM_W'(r_pn[2]) + w_d;
        w_sum_f = SUM_W'(r_pf[0]) + SUM_W'(r_pf[1]) + SUM_W'(r_pf[2]) + w_d;
        w_pos_n = !w_sum_n[SUM_W-1] && (|w_sum_n);
        w_pos_f = !w_sum_f[SUM_W-1] && (|w_sum_f);
        n_s2_item = r_s1_item;
        n_s2_item.flags.out_plane = r_s1_item.flags.out_plane | w_pos_n;
        n_s2_item.flags.crossing  = r_s1_item.flags.crossing | w_pos_f;
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

endmodule

// ===== hw/rtl/frustum_aabb_cull.sv =====
// top level of the frustum box culling block: config registers, cell chain, output skid
// depends on fac_pkg, fac_box_cell and fac_plane_cell
//
// channel   | direction | fields
// ----------+-----------+------------------------------------------------------------
// s_axis    | in        | tuser: opcode; tdata: slot, coefficient, box lo/hi xyz
// m_axis    | out       | tdata: verdict
// cfg       | in        | i_cfg_index, i_cfg_data: frustum box bounds
//
// one request per cycle while the skid register is empty; a box test's verdict passes through
// the box cell, two stages per plane cell and the output register
// the whole chain advances together; it holds only when the skid register is full
// synchronous active-low reset clears valid bits and the frustum bounds

module frustum_aabb_cull
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] opcode
    input  logic                  s_axis_tuser,
    // [2:0] plane_slot, [4:3] coef_slot, [36:5] coef_value, [68:37] box_lo_x,
    // [100:69] box_lo_y, [132:101] box_lo_z, [164:133] box_hi_x,
    // [196:165] box_hi_y, [228:197] box_hi_z, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] verdict, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VAL_W-1:0]      i_cfg_data
);

    t_vec3      r_fmin;
    t_vec3      r_fmax;
    logic       r_out_valid;
    logic [1:0] r_out_verdict;
    logic       r_skid_valid;
    logic [1:0] r_skid_verdict;

    logic       w_en;
    t_item      w_in_item;
    logic       w_valid [NUM_PLANES+1];
    t_item      w_item  [NUM_PLANES+1];
    logic       w_res_valid;
    logic [1:0] w_res_verdict;
    t_flags     w_tail_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmin <= '0;
            r_fmax <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_X: r_fmin[0] <= i_cfg_data;
                REG_MIN_Y: r_fmin[1] <= i_cfg_data;
                REG_MIN_Z: r_fmin[2] <= i_cfg_data;
                REG_MAX_X: r_fmax[0] <= i_cfg_data;
                REG_MAX_Y: r_fmax[1] <= i_cfg_data;
                REG_MAX_Z: r_fmax[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    always_comb begin
        w_in_item.opcode     = s_axis_tuser;
        w_in_item.plane_slot = s_axis_tdata[2:0];
        w_in_item.coef_slot  = s_axis_tdata[4:3];
        w_in_item.coef_value = s_axis_tdata[36:5];
        w_in_item.lo[0]      = s_axis_tdata[68:37];
        w_in_item.lo[1]      = s_axis_tdata[100:69];
        w_in_item.lo[2]      = s_axis_tdata[132:101];
        w_in_item.hi[0]      = s_axis_tdata[164:133];
        w_in_item.hi[1]      = s_axis_tdata[196:165];
        w_in_item.hi[2]      = s_axis_tdata[228:197];
        w_in_item.flags      = '0;
    end

    fac_box_cell u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_fmin  (r_fmin),
        .i_fmax  (r_fmax),
        .i_valid (s_axis_tvalid),
        .i_item  (w_in_item),
        .o_valid (w_valid[0]),
        .o_item  (w_item[0])
    );

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        fac_plane_cell u_plane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (PLANE_W'(g)),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign w_tail_flags = w_item[NUM_PLANES].flags;
    assign w_res_valid  = w_en && w_valid[NUM_PLANES] && w_item[NUM_PLANES].opcode == OP_TEST;

    always_comb begin
        priority if (w_tail_flags.out_box) begin
            w_res_verdict = VERDICT_OUT_BOX;
        end else if (w_tail_flags.out_plane) begin
            w_res_verdict = VERDICT_OUT_PLANE;
        end else if (w_tail_flags.crossing) begin
            w_res_verdict = VERDICT_CROSS;
        end else begin
            w_res_verdict = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_axis_tready) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_res_valid) begin
                if (r_out_valid && !m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_verdict <= r_skid_verdict;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_verdict <= w_res_verdict;
            end else begin
                r_out_verdict <= w_res_verdict;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_verdict};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !s_axis_tready)
        else $error("input accepted while the skid register is full");

    a_blocked_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && r_out_valid && !m_axis_tready |=> r_skid_valid && r_out_valid)
        else $error("result leaving the chain was dropped");

endmodule
